// ===== hw/rtl/nand_page_read_sequencer_macros.svh =====
// Assertion macros for the RTL
`ifndef NAND_PAGE_READ_SEQUENCER_MACROS_SVH
`define NAND_PAGE_READ_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define NPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define NPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/npr_pkg.sv =====
package npr_pkg;

   // Page geometry
   localparam int unsigned PageBytes = 2048;
   localparam int unsigned PageShift = $clog2(PageBytes);
   localparam int unsigned ColWidth  = 12;

   // Burst buffer: select/data, then up to seven more results
   localparam int unsigned BurstDepth = 8;
   localparam int unsigned BurstIdxW  = $clog2(BurstDepth);

   // Input actions
   localparam logic [1:0] ActStart = 2'd0;
   localparam logic [1:0] ActReady = 2'd1;
   localparam logic [1:0] ActByte  = 2'd2;

   // Result kinds
   localparam logic [2:0] KindSelect   = 3'd0;
   localparam logic [2:0] KindDeselect = 3'd1;
   localparam logic [2:0] KindCmd      = 3'd2;
   localparam logic [2:0] KindAddr     = 3'd3;
   localparam logic [2:0] KindData     = 3'd4;

   // Flash commands
   localparam logic [7:0] CmdRead1 = 8'h00;
   localparam logic [7:0] CmdRead2 = 8'h30;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
   } result_type;

endpackage

// ===== hw/rtl/nand_page_read_sequencer.sv =====
// Channel | Dir | tdata (low bit up)                                | tuser      | tlast
// req_    | in  | start_address, byte_count, ready_flag, flash_byte | action     | -
// rsp_    | out | value                                             | kind       | last
//
// Each item is decoded in the cycle it is accepted and its results land in an
// eight-entry burst register, drained one result per cycle while rsp_tready is high.
// A flash byte inside a page gives one result, so with rsp_tready high data streams
// at one item per cycle; a start gives two or eight results, the last byte of a read
// two and the last byte of a page eight, and req_tready stays low until the burst's
// last result is taken. Ready samples give no result.
// Reset (synchronous, active high) returns to idle with an empty burst register.
// A stalled rsp_ side holds the burst; req_ is taken again in the cycle the
// burst's last result leaves.
`include "nand_page_read_sequencer_macros.svh"

module nand_page_read_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_address [31:0], byte_count [63:32], ready_flag [64], flash_byte [72:65]
   input  logic [79:0] req_tdata,
   // action [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value [7:0]
   output logic [7:0]  rsp_tdata,
   // kind [2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {
      PhIdle,
      PhWait,
      PhRead
   } phase_type;

   localparam int unsigned IdxW = npr_pkg::BurstIdxW;
   localparam int unsigned ColW = npr_pkg::ColWidth;
   localparam logic [31:0] ColMask = 32'(npr_pkg::PageBytes - 1);

   phase_type            phase_ff, phase_in;
   logic [31:0]          addr_ff, addr_in;
   logic [31:0]          left_ff, left_in;
   logic [ColW-1:0]      column_ff, column_in;
   logic                 burst_valid_ff, burst_valid_in;
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic [IdxW-1:0]      cnt_ff, cnt_in;
   npr_pkg::result_type  burst_ff [npr_pkg::BurstDepth];
   npr_pkg::result_type  burst_in [npr_pkg::BurstDepth];

   logic                 req_accept;
   logic                 burst_end;
   logic [1:0]           in_action;
   logic [31:0]          in_start;
   logic [31:0]          in_count;
   logic                 in_ready;
   logic [7:0]           in_byte;
   logic [31:0]          next_addr;
   logic [31:0]          left_dec;
   logic [ColW-1:0]      col_inc;
   logic [31:0]          open_addr;
   logic [31:0]          open_col;
   logic [31:0]          open_page;
   logic                 col_in_step;

   // Field unpacking
   assign in_action = req_tuser;
   assign in_start  = req_tdata[31:0];
   assign in_count  = req_tdata[63:32];
   assign in_ready  = req_tdata[64];
   assign in_byte   = req_tdata[72:65];

   // Handshakes
   assign burst_end  = burst_valid_ff && rsp_tready && (idx_ff == cnt_ff);
   assign req_tready = !burst_valid_ff || burst_end;
   assign req_accept = req_tvalid && req_tready;

   // Result output from the burst register
   assign rsp_tvalid = burst_valid_ff;
   assign rsp_tuser  = burst_ff[idx_ff].kind;
   assign rsp_tdata  = burst_ff[idx_ff].value;
   assign rsp_tlast  = (idx_ff == cnt_ff);

   // Read step arithmetic
   assign next_addr = addr_ff + 32'd1;
   assign left_dec  = left_ff - 32'd1;
   assign col_inc   = column_ff + ColW'(1);

   // Page-open address bytes: start address or the advanced address
   assign open_addr = (in_action == npr_pkg::ActStart) ? in_start : next_addr;
   assign open_col  = open_addr & ColMask;
   assign open_page = open_addr >> npr_pkg::PageShift;

   always_comb begin
      phase_in       = phase_ff;
      addr_in        = addr_ff;
      left_in        = left_ff;
      column_in      = column_ff;
      burst_valid_in = burst_valid_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      burst_in       = burst_ff;

      // Drain
      if (burst_valid_ff && rsp_tready) begin
         if (idx_ff == cnt_ff) begin
            burst_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + IdxW'(1);
         end
      end

      // Page-open sequence fills entries one to seven; a deselect overwrites entry one
      burst_in[1] = '{kind: npr_pkg::KindCmd,  value: npr_pkg::CmdRead1};
      burst_in[2] = '{kind: npr_pkg::KindAddr, value: open_col[7:0]};
      burst_in[3] = '{kind: npr_pkg::KindAddr, value: open_col[15:8]};
      burst_in[4] = '{kind: npr_pkg::KindAddr, value: open_page[7:0]};
      burst_in[5] = '{kind: npr_pkg::KindAddr, value: open_page[15:8]};
      burst_in[6] = '{kind: npr_pkg::KindAddr, value: open_page[23:16]};
      burst_in[7] = '{kind: npr_pkg::KindCmd,  value: npr_pkg::CmdRead2};
      if (!req_accept) begin
         burst_in = burst_ff;
      end

      // Item decode
      if (req_accept) begin
         case (in_action)
            npr_pkg::ActStart: begin
               if (phase_ff == PhIdle) begin
                  addr_in        = in_start;
                  left_in        = in_count;
                  column_in      = ColW'(in_start & ColMask);
                  burst_in[0]    = '{kind: npr_pkg::KindSelect, value: 8'h00};
                  burst_valid_in = 1'b1;
                  idx_in         = '0;
                  if (in_count == 32'd0) begin
                     burst_in[1] = '{kind: npr_pkg::KindDeselect, value: 8'h00};
                     cnt_in      = IdxW'(1);
                  end else begin
                     cnt_in   = IdxW'(npr_pkg::BurstDepth - 1);
                     phase_in = PhWait;
                  end
               end
            end
            npr_pkg::ActReady: begin
               if (phase_ff == PhWait && in_ready) begin
                  phase_in = PhRead;
               end
            end
            npr_pkg::ActByte: begin
               if (phase_ff == PhRead) begin
                  addr_in        = next_addr;
                  left_in        = left_dec;
                  column_in      = col_inc;
                  burst_in[0]    = '{kind: npr_pkg::KindData, value: in_byte};
                  burst_valid_in = 1'b1;
                  idx_in         = '0;
                  if (left_dec == 32'd0) begin
                     burst_in[1] = '{kind: npr_pkg::KindDeselect, value: 8'h00};
                     cnt_in      = IdxW'(1);
                     phase_in    = PhIdle;
                  end else if (col_inc >= ColW'(npr_pkg::PageBytes)) begin
                     column_in = '0;
                     cnt_in    = IdxW'(npr_pkg::BurstDepth - 1);
                     phase_in  = PhWait;
                  end else begin
                     cnt_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State and burst registers
   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
      if (reset) begin
         phase_ff       <= PhIdle;
         addr_ff        <= '0;
         left_ff        <= '0;
         column_ff      <= '0;
         burst_valid_ff <= 1'b0;
         idx_ff         <= '0;
         cnt_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         addr_ff        <= addr_in;
         left_ff        <= left_in;
         column_ff      <= column_in;
         burst_valid_ff <= burst_valid_in;
         idx_ff         <= idx_in;
         cnt_ff         <= cnt_in;
      end
   end

   // Checks
   assign col_in_step = (32'(column_ff) == (addr_ff & ColMask));

   `NPR_ASSERT_NOW(a_idx_in_range, burst_valid_ff, idx_ff <= cnt_ff, "burst index past count")
   `NPR_ASSERT_NOW(a_read_has_bytes, phase_ff == PhRead, left_ff != 32'd0, "read, none left")
   `NPR_ASSERT_NOW(a_col_tracks_addr, phase_ff != PhIdle, col_in_step, "column off address")
   `NPR_ASSERT_NEXT(a_burst_empties, burst_end && !req_accept, !rsp_tvalid, "result after end")

endmodule
